>>> rtl/tcp_pkg.sv
// Shared widths, types and codes for the triangle closest point pipeline.
// No dependencies; used by rtl/triangle_closest_point.sv.
package tcp_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // Weight word and quotient bits (one spare bit to catch saturation).
  localparam int WW = 32;
  localparam int QB = WW + 1;

  localparam int C    = COORD_BITS;
  localparam int DW   = C + 1;          // coordinate difference
  localparam int PW   = 2 * DW;         // difference product
  localparam int DOTW = PW + 2;         // dot product of three terms
  localparam int HL   = DOTW / 2;       // low half of a split operand
  localparam int HH   = DOTW - HL;      // high half of a split operand
  localparam int PHW  = DOTW + HH;      // high partial product
  localparam int PLW  = DOTW + HL + 1;  // low partial product
  localparam int XW   = 2 * DOTW;       // full dot by dot product
  localparam int VW   = XW + 1;         // barycentric triple term
  localparam int EW   = DOTW + 1;       // dot difference
  localparam int FW   = VW + 2;         // sum of three triple terms
  localparam int MW   = FW;             // magnitude into the divider
  localparam int RW   = MW + FRAC_BITS + QB + 1;  // divider working width
  localparam int MPW  = WW + DW;        // weight by direction product
  localparam int OW   = MPW + 1;        // sum of two such products

  localparam int ITDW = ((12 * C + 7) / 8) * 8;
  localparam int OTDW = ((3 * C + 7) / 8) * 8;
  localparam int OTUW = 8;

  typedef logic signed [C-1:0]    crd_t;
  typedef logic signed [DW-1:0]   dif_t;
  typedef logic signed [PW-1:0]   prd_t;
  typedef logic signed [DOTW-1:0] dot_t;
  typedef logic signed [PHW-1:0]  phi_t;
  typedef logic signed [PLW-1:0]  plo_t;
  typedef logic signed [XW-1:0]   xw_t;
  typedef logic signed [VW-1:0]   vw_t;
  typedef logic signed [EW-1:0]   ew_t;
  typedef logic signed [FW-1:0]   fw_t;
  typedef logic        [MW-1:0]   mag_t;
  typedef logic        [RW-1:0]   rw_t;
  typedef logic signed [WW-1:0]   wgt_t;
  typedef logic signed [MPW-1:0]  mpw_t;
  typedef logic signed [OW-1:0]   ow_t;
  typedef logic signed [OW:0]     osum_t;

  localparam logic [QB-1:0] QPOS = {2'b00, {(WW-1){1'b1}}};
  localparam logic [QB-1:0] QNEG = {2'b01, {(WW-1){1'b0}}};
  localparam wgt_t WMAX = {1'b0, {(WW-1){1'b1}}};
  localparam wgt_t WMIN = {1'b1, {(WW-1){1'b0}}};
  localparam osum_t CMAX = {{(OW+2-C){1'b0}}, {(C-1){1'b1}}};
  localparam osum_t CMIN = {{(OW+2-C){1'b1}}, {(C-1){1'b0}}};

  typedef enum logic [2:0] {
    RG_VERT_A  = 3'd0,
    RG_VERT_B  = 3'd1,
    RG_EDGE_AB = 3'd2,
    RG_VERT_C  = 3'd3,
    RG_EDGE_AC = 3'd4,
    RG_EDGE_BC = 3'd5,
    RG_FACE    = 3'd6
  } region_t;

  typedef struct packed {
    crd_t [2:0] a;
    crd_t [2:0] b;
    crd_t [2:0] c;
    dif_t [2:0] ab;
    dif_t [2:0] ac;
    dif_t [2:0] bc;
  } geo_t;

  typedef struct packed {
    crd_t [2:0] base;
    dif_t [2:0] dir1;
    dif_t [2:0] dir2;
    region_t    region;
    logic       deg;
  } ctx_t;

  typedef struct packed {
    rw_t           rem;
    mag_t          den;
    logic [QB-1:0] quo;
    logic          neg;
    logic          ovf;
    logic          zero;
  } lane_t;

endpackage

>>> rtl/triangle_closest_point.sv
// Closest point on a triangle to a query point, fully pipelined.
// Depends on rtl/tcp_pkg.sv for widths, types and region codes.
//
// Usage:
//  - Slave stream (s_tvalid/s_tready/s_tdata) carries one request: vertices
//    A, B, C and the query point, twelve signed Q8.8 coordinates.
//  - Master stream (m_tvalid/m_tready/m_tdata/m_tuser) returns one result
//    per request, in order: the closest point in tdata, region code,
//    inside flag and degenerate flag in tuser.
//  - Throughput: one request per cycle while m_tready stays high. Depth: 12 + QB
//    register stages. The latency is set by the two restoring dividers, one
//    quotient bit per stage, that produce the edge and face weights.
//  - Each stage holds its own valid bit and advances when it is empty or the
//    stage after it advances, so bubbles close up while the receiver stalls;
//    s_tready drops only once every stage holds a request.
//  - Reset (rst, synchronous) clears all valid bits; data registers are not
//    reset. A stalled result holds on the master side until taken.
//  - Region and weight decisions are exact; weights are truncated toward
//    zero and saturated to 32 bits, the point is floored and clamped.
module triangle_closest_point (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
  // vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z
  input  logic [tcp_pkg::ITDW-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // near_x, near_y, near_z
  output logic [tcp_pkg::OTDW-1:0]     m_tdata,
  // region[2:0], inside_res, degenerate, zero fill
  output logic [tcp_pkg::OTUW-1:0]     m_tuser
);

  localparam int QB  = tcp_pkg::QB;
  localparam int NST = 12 + QB;
  localparam int DV0 = 8;            // stage index of divider setup
  localparam int SAT = 9 + QB;
  localparam int MUL = 10 + QB;
  localparam int OUT = 11 + QB;
  localparam int C   = tcp_pkg::C;

  // Operand pairs for the triple terms: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PY [6] = '{3, 1, 1, 5, 5, 3};

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en[NST-1] = !vld[NST-1] || m_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: unpack, form edge and query differences.
  tcp_pkg::crd_t pin [4][3];
  always_comb begin
    for (int v = 0; v < 4; v++) begin
      for (int k = 0; k < 3; k++) begin
        pin[v][k] = tcp_pkg::crd_t'(s_tdata[(3*v+k)*C +: C]);
      end
    end
  end

  tcp_pkg::geo_t  s1_geo;
  tcp_pkg::dif_t  s1_ap [3];
  tcp_pkg::dif_t  s1_bp [3];
  tcp_pkg::dif_t  s1_cp [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        s1_geo.a[k]  <= pin[0][k];
        s1_geo.b[k]  <= pin[1][k];
        s1_geo.c[k]  <= pin[2][k];
        s1_geo.ab[k] <= tcp_pkg::dif_t'(pin[1][k]) - tcp_pkg::dif_t'(pin[0][k]);
        s1_geo.ac[k] <= tcp_pkg::dif_t'(pin[2][k]) - tcp_pkg::dif_t'(pin[0][k]);
        s1_geo.bc[k] <= tcp_pkg::dif_t'(pin[2][k]) - tcp_pkg::dif_t'(pin[1][k]);
        s1_ap[k]     <= tcp_pkg::dif_t'(pin[3][k]) - tcp_pkg::dif_t'(pin[0][k]);
        s1_bp[k]     <= tcp_pkg::dif_t'(pin[3][k]) - tcp_pkg::dif_t'(pin[1][k]);
        s1_cp[k]     <= tcp_pkg::dif_t'(pin[3][k]) - tcp_pkg::dif_t'(pin[2][k]);
      end
    end
  end

  // Stage 2: the eighteen component products of d1..d6.
  tcp_pkg::geo_t s2_geo;
  tcp_pkg::prd_t s2_prd [6][3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_geo <= s1_geo;
      for (int k = 0; k < 3; k++) begin
        s2_prd[0][k] <= $signed(s1_geo.ab[k]) * $signed(s1_ap[k]);
        s2_prd[1][k] <= $signed(s1_geo.ac[k]) * $signed(s1_ap[k]);
        s2_prd[2][k] <= $signed(s1_geo.ab[k]) * $signed(s1_bp[k]);
        s2_prd[3][k] <= $signed(s1_geo.ac[k]) * $signed(s1_bp[k]);
        s2_prd[4][k] <= $signed(s1_geo.ab[k]) * $signed(s1_cp[k]);
        s2_prd[5][k] <= $signed(s1_geo.ac[k]) * $signed(s1_cp[k]);
      end
    end
  end

  // Stage 3: sum into the dot products d1..d6 (index 0..5).
  tcp_pkg::geo_t s3_geo;
  tcp_pkg::dot_t s3_dot [6];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_geo <= s2_geo;
      for (int j = 0; j < 6; j++) begin
        s3_dot[j] <= tcp_pkg::dot_t'(s2_prd[j][0]) + tcp_pkg::dot_t'(s2_prd[j][1])
                   + tcp_pkg::dot_t'(s2_prd[j][2]);
      end
    end
  end

  // Stage 4: split dot by dot products into two partial products each.
  tcp_pkg::geo_t s4_geo;
  tcp_pkg::dot_t s4_dot [6];
  tcp_pkg::phi_t s4_ph  [6];
  tcp_pkg::plo_t s4_pl  [6];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_geo <= s3_geo;
      s4_dot <= s3_dot;
      for (int j = 0; j < 6; j++) begin
        s4_ph[j] <= $signed(s3_dot[PX[j]])
                  * $signed(s3_dot[PY[j]][tcp_pkg::DOTW-1:tcp_pkg::HL]);
        s4_pl[j] <= $signed(s3_dot[PX[j]])
                  * $signed({1'b0, s3_dot[PY[j]][tcp_pkg::HL-1:0]});
      end
    end
  end

  // Stage 5: combine the partials.
  tcp_pkg::geo_t s5_geo;
  tcp_pkg::dot_t s5_dot [6];
  tcp_pkg::xw_t  s5_prd [6];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_geo <= s4_geo;
      s5_dot <= s4_dot;
      for (int j = 0; j < 6; j++) begin
        s5_prd[j] <= (tcp_pkg::xw_t'(s4_ph[j]) <<< tcp_pkg::HL) + tcp_pkg::xw_t'(s4_pl[j]);
      end
    end
  end

  // Stage 6: triple terms and the two dot differences.
  tcp_pkg::geo_t s6_geo;
  tcp_pkg::dot_t s6_dot [6];
  tcp_pkg::vw_t  s6_va, s6_vb, s6_vc;
  tcp_pkg::ew_t  s6_d43, s6_d56;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_geo <= s5_geo;
      s6_dot <= s5_dot;
      s6_vc  <= tcp_pkg::vw_t'(s5_prd[0]) - tcp_pkg::vw_t'(s5_prd[1]);
      s6_vb  <= tcp_pkg::vw_t'(s5_prd[2]) - tcp_pkg::vw_t'(s5_prd[3]);
      s6_va  <= tcp_pkg::vw_t'(s5_prd[4]) - tcp_pkg::vw_t'(s5_prd[5]);
      s6_d43 <= tcp_pkg::ew_t'(s5_dot[3]) - tcp_pkg::ew_t'(s5_dot[2]);
      s6_d56 <= tcp_pkg::ew_t'(s5_dot[4]) - tcp_pkg::ew_t'(s5_dot[5]);
    end
  end

  // Stage 7: Voronoi region test, face divisor.
  tcp_pkg::region_t rg_next;
  always_comb begin
    if (s6_dot[0] <= 0 && s6_dot[1] <= 0) begin
      rg_next = tcp_pkg::RG_VERT_A;
    end else if (s6_dot[2] >= 0 && s6_d43 <= 0) begin
      rg_next = tcp_pkg::RG_VERT_B;
    end else if (s6_vc <= 0 && s6_dot[0] >= 0 && s6_dot[2] <= 0) begin
      rg_next = tcp_pkg::RG_EDGE_AB;
    end else if (s6_dot[5] >= 0 && s6_d56 <= 0) begin
      rg_next = tcp_pkg::RG_VERT_C;
    end else if (s6_vb <= 0 && s6_dot[1] >= 0 && s6_dot[5] <= 0) begin
      rg_next = tcp_pkg::RG_EDGE_AC;
    end else if (s6_va <= 0 && s6_d43 >= 0 && s6_d56 >= 0) begin
      rg_next = tcp_pkg::RG_EDGE_BC;
    end else begin
      rg_next = tcp_pkg::RG_FACE;
    end
  end

  tcp_pkg::geo_t    s7_geo;
  tcp_pkg::region_t s7_region;
  tcp_pkg::dot_t    s7_dot [6];
  tcp_pkg::ew_t     s7_d43, s7_d56;
  tcp_pkg::vw_t     s7_vb, s7_vc;
  tcp_pkg::fw_t     s7_fden;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_geo    <= s6_geo;
      s7_region <= rg_next;
      s7_dot    <= s6_dot;
      s7_d43    <= s6_d43;
      s7_d56    <= s6_d56;
      s7_vb     <= s6_vb;
      s7_vc     <= s6_vc;
      s7_fden   <= tcp_pkg::fw_t'(s6_va) + tcp_pkg::fw_t'(s6_vb) + tcp_pkg::fw_t'(s6_vc);
    end
  end

  // Stage 8: pick numerators, divisors and geometry for the region.
  function automatic tcp_pkg::mag_t fmag(tcp_pkg::fw_t x);
    tcp_pkg::fw_t n;
    n = -x;
    return x[tcp_pkg::FW-1] ? tcp_pkg::mag_t'(n) : tcp_pkg::mag_t'(x);
  endfunction

  tcp_pkg::fw_t  n1, n2, dn1, dn2;
  logic          use1, use2;
  tcp_pkg::ctx_t ctx_next;

  always_comb begin
    n1   = '0;
    n2   = '0;
    dn1  = '0;
    dn2  = '0;
    use1 = 1'b0;
    use2 = 1'b0;
    ctx_next.base   = s7_geo.a;
    ctx_next.dir1   = s7_geo.ab;
    ctx_next.dir2   = s7_geo.ac;
    ctx_next.region = s7_region;
    case (s7_region)
      tcp_pkg::RG_VERT_A: begin
        ctx_next.base = s7_geo.a;
      end
      tcp_pkg::RG_VERT_B: begin
        ctx_next.base = s7_geo.b;
      end
      tcp_pkg::RG_VERT_C: begin
        ctx_next.base = s7_geo.c;
      end
      tcp_pkg::RG_EDGE_AB: begin
        n1   = tcp_pkg::fw_t'(s7_dot[0]);
        dn1  = tcp_pkg::fw_t'(s7_dot[0]) - tcp_pkg::fw_t'(s7_dot[2]);
        use1 = 1'b1;
      end
      tcp_pkg::RG_EDGE_AC: begin
        n1   = tcp_pkg::fw_t'(s7_dot[1]);
        dn1  = tcp_pkg::fw_t'(s7_dot[1]) - tcp_pkg::fw_t'(s7_dot[5]);
        use1 = 1'b1;
        ctx_next.dir1 = s7_geo.ac;
      end
      tcp_pkg::RG_EDGE_BC: begin
        n1   = tcp_pkg::fw_t'(s7_d43);
        dn1  = tcp_pkg::fw_t'(s7_d43) + tcp_pkg::fw_t'(s7_d56);
        use1 = 1'b1;
        ctx_next.base = s7_geo.b;
        ctx_next.dir1 = s7_geo.bc;
      end
      tcp_pkg::RG_FACE: begin
        n1   = tcp_pkg::fw_t'(s7_vb);
        n2   = tcp_pkg::fw_t'(s7_vc);
        dn1  = s7_fden;
        dn2  = s7_fden;
        use1 = 1'b1;
        use2 = 1'b1;
      end
      default: begin
        ctx_next.base = s7_geo.a;
      end
    endcase
    ctx_next.deg = (use1 && dn1 == 0) || (use2 && dn2 == 0);
  end

  tcp_pkg::ctx_t s8_ctx;
  tcp_pkg::mag_t s8_nm1, s8_nm2, s8_dm1, s8_dm2;
  logic          s8_neg1, s8_neg2, s8_zero1, s8_zero2;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_ctx   <= ctx_next;
      s8_nm1   <= fmag(n1);
      s8_nm2   <= fmag(n2);
      s8_dm1   <= fmag(dn1);
      s8_dm2   <= fmag(dn2);
      s8_neg1  <= n1[tcp_pkg::FW-1] ^ dn1[tcp_pkg::FW-1];
      s8_neg2  <= n2[tcp_pkg::FW-1] ^ dn2[tcp_pkg::FW-1];
      s8_zero1 <= !use1 || dn1 == 0;
      s8_zero2 <= !use2 || dn2 == 0;
    end
  end

  // Divider setup (index 0) and one quotient bit per stage (1..QB).
  tcp_pkg::lane_t dv1  [QB+1];
  tcp_pkg::lane_t dv2  [QB+1];
  tcp_pkg::ctx_t  dvc  [QB+1];
  tcp_pkg::lane_t dv1n [QB+1];
  tcp_pkg::lane_t dv2n [QB+1];

  function automatic tcp_pkg::lane_t dset(tcp_pkg::mag_t nm, tcp_pkg::mag_t dm,
                                          logic neg, logic zero);
    tcp_pkg::lane_t l;
    l.rem  = tcp_pkg::rw_t'(nm) << tcp_pkg::FRAC_BITS;
    l.den  = dm;
    l.quo  = '0;
    l.neg  = neg;
    l.zero = zero;
    l.ovf  = l.rem >= (tcp_pkg::rw_t'(dm) << QB);
    return l;
  endfunction

  always_comb begin
    dv1n[0] = dset(s8_nm1, s8_dm1, s8_neg1, s8_zero1);
    dv2n[0] = dset(s8_nm2, s8_dm2, s8_neg2, s8_zero2);
    for (int t = 1; t <= QB; t++) begin
      dv1n[t] = dv1[t-1];
      dv2n[t] = dv2[t-1];
      if (dv1[t-1].rem >= (tcp_pkg::rw_t'(dv1[t-1].den) << (QB - t))) begin
        dv1n[t].rem       = dv1[t-1].rem - (tcp_pkg::rw_t'(dv1[t-1].den) << (QB - t));
        dv1n[t].quo[QB-t] = 1'b1;
      end
      if (dv2[t-1].rem >= (tcp_pkg::rw_t'(dv2[t-1].den) << (QB - t))) begin
        dv2n[t].rem       = dv2[t-1].rem - (tcp_pkg::rw_t'(dv2[t-1].den) << (QB - t));
        dv2n[t].quo[QB-t] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t <= QB; t++) begin
      if (en[DV0+t]) begin
        dv1[t] <= dv1n[t];
        dv2[t] <= dv2n[t];
        dvc[t] <= (t == 0) ? s8_ctx : dvc[(t == 0) ? 0 : t-1];
      end
    end
  end

  // Apply sign, saturate to the weight word; a zero or unused lane gives 0.
  function automatic tcp_pkg::wgt_t wsat(tcp_pkg::lane_t l);
    tcp_pkg::wgt_t w;
    logic [QB-1:0] nq;
    nq = -l.quo;
    if (l.zero) begin
      w = '0;
    end else if (!l.neg) begin
      w = (l.ovf || l.quo > tcp_pkg::QPOS) ? tcp_pkg::WMAX : tcp_pkg::wgt_t'(l.quo);
    end else begin
      w = (l.ovf || l.quo > tcp_pkg::QNEG) ? tcp_pkg::WMIN : tcp_pkg::wgt_t'(nq);
    end
    return w;
  endfunction

  tcp_pkg::ctx_t sat_ctx;
  tcp_pkg::wgt_t sat_w1, sat_w2;

  always_ff @(posedge clk) begin
    if (en[SAT]) begin
      sat_ctx <= dvc[QB];
      sat_w1  <= wsat(dv1[QB]);
      sat_w2  <= wsat(dv2[QB]);
    end
  end

  // Weight by direction products.
  tcp_pkg::crd_t    mul_base [3];
  tcp_pkg::mpw_t    mul_m1 [3];
  tcp_pkg::mpw_t    mul_m2 [3];
  tcp_pkg::region_t mul_region;
  logic             mul_deg;

  always_ff @(posedge clk) begin
    if (en[MUL]) begin
      mul_region <= sat_ctx.region;
      mul_deg    <= sat_ctx.deg;
      for (int k = 0; k < 3; k++) begin
        mul_base[k] <= sat_ctx.base[k];
        mul_m1[k]   <= $signed(sat_w1) * $signed(sat_ctx.dir1[k]);
        mul_m2[k]   <= $signed(sat_w2) * $signed(sat_ctx.dir2[k]);
      end
    end
  end

  // Output stage: floor shift, add base, clamp to the coordinate range.
  tcp_pkg::ow_t     off [3];
  tcp_pkg::osum_t   psum [3];
  tcp_pkg::crd_t    near_next [3];
  tcp_pkg::crd_t    out_near [3];
  tcp_pkg::region_t out_region;
  logic             out_deg;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off[k]  = (tcp_pkg::ow_t'(mul_m1[k]) + tcp_pkg::ow_t'(mul_m2[k])) >>> tcp_pkg::FRAC_BITS;
      psum[k] = tcp_pkg::osum_t'(off[k]) + tcp_pkg::osum_t'(mul_base[k]);
      if (psum[k] > tcp_pkg::CMAX) begin
        near_next[k] = tcp_pkg::crd_t'(tcp_pkg::CMAX);
      end else if (psum[k] < tcp_pkg::CMIN) begin
        near_next[k] = tcp_pkg::crd_t'(tcp_pkg::CMIN);
      end else begin
        near_next[k] = tcp_pkg::crd_t'(psum[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUT]) begin
      out_near   <= near_next;
      out_region <= mul_region;
      out_deg    <= mul_deg;
    end
  end

  assign m_tvalid = vld[OUT];
  assign m_tdata  = tcp_pkg::OTDW'({out_near[2], out_near[1], out_near[0]});
  assign m_tuser  = tcp_pkg::OTUW'({out_deg, out_region == tcp_pkg::RG_FACE, out_region});

  // A zero divisor can only come from a region that divides.
  a_deg_region: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[4] |-> (m_tuser[2:0] == tcp_pkg::RG_EDGE_AB ||
      m_tuser[2:0] == tcp_pkg::RG_EDGE_AC || m_tuser[2:0] == tcp_pkg::RG_EDGE_BC ||
      m_tuser[2:0] == tcp_pkg::RG_FACE))
    else $error("degenerate flag on a vertex region");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A finished division leaves a remainder below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[DV0+QB] && !dv1[QB].ovf && !dv1[QB].zero |->
      dv1[QB].rem < tcp_pkg::rw_t'(dv1[QB].den))
    else $error("divider remainder not reduced");

  // An accepted request lands in the first stage.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted request lost at entry");

endmodule
